// ----- rtl/i2cbs_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Command codes, register indexes, sequencer state type and the phase-entry
// function of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

  // Command codes on the input tuser; CMD_WACK_TAIL is internal only
  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_START     = 4'd1;
  localparam logic [3:0] CMD_STOP      = 4'd2;
  localparam logic [3:0] CMD_WRITE     = 4'd3;
  localparam logic [3:0] CMD_READ      = 4'd4;
  localparam logic [3:0] CMD_ACK       = 4'd5;
  localparam logic [3:0] CMD_NACK      = 4'd6;
  localparam logic [3:0] CMD_WAIT_ACK  = 4'd7;
  localparam logic [3:0] CMD_WRITE_ACK = 4'd8;
  localparam logic [3:0] CMD_WACK_TAIL = 4'd9;
  localparam logic [3:0] CMD_LAST      = CMD_WRITE_ACK;

  // Status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_INVALID = 2'd1;
  localparam logic [1:0] STS_BUSY    = 2'd2;

  // Configuration register indexes
  localparam logic REG_PHASE_TICKS    = 1'b0;
  localparam logic REG_ACK_POLL_LIMIT = 1'b1;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd200;
  localparam logic [3:0]  POLL_LIMIT_RST  = 4'd10;

  // Phase numbering
  localparam logic [4:0] WRITE_LAST_PHASE = 5'd24;
  localparam logic [4:0] READ_LAST_PHASE  = 5'd16;
  localparam logic [4:0] TAB_LAST_PHASE   = 5'd4;
  localparam logic [4:0] POLL_PHASE       = 5'd5;
  localparam logic [3:0] POLL_CNT_MAX     = 4'd15;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       sda_en;
    logic [3:0] cmd;
    logic [4:0] phase;
    logic [7:0] shift;
    logic [3:0] bit_cnt;
    logic [3:0] poll_cnt;
    logic       ack_fail;
    logic [7:0] read_byte;
  } seq_state_t;

  typedef struct packed {
    seq_state_t st;
    logic       ok;
  } enter_res_t;

  // Position within a write bit slot (SDA set, SCL high, SCL low)
  function automatic logic [1:0] bit_slot(input logic [4:0] x);
    logic [1:0] r;
    case (x) inside
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21: r = 2'd0;
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22: r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  // Enter the current phase of the current command; ok low once the list ends
  function automatic enter_res_t enter_phase(input seq_state_t s, input logic sda_in);
    enter_res_t r;
    logic [4:0] idx;
    r.st = s;
    r.ok = 1'b1;
    idx  = s.phase;
    case (s.cmd)
      CMD_WRITE, CMD_WRITE_ACK: begin
        if (idx == 5'd0) begin
          r.st.sda_en  = 1'b1;
          r.st.bit_cnt = 4'd0;
        end else if (idx > WRITE_LAST_PHASE) begin
          r.ok = 1'b0;
        end else begin
          case (bit_slot(idx - 5'd1))
            2'd0: r.st.sda = s.shift[7];
            2'd1: r.st.scl = 1'b1;
            default: begin
              r.st.scl     = 1'b0;
              r.st.shift   = {s.shift[6:0], 1'b0};
              r.st.bit_cnt = s.bit_cnt + 4'd1;
            end
          endcase
        end
      end
      CMD_READ: begin
        if (idx == 5'd0) begin
          r.st.sda_en  = 1'b0;
          r.st.bit_cnt = 4'd0;
          r.st.shift   = 8'd0;
        end else if (idx > READ_LAST_PHASE) begin
          r.st.read_byte = s.shift;
          r.ok           = 1'b0;
        end else if (idx[0]) begin
          r.st.scl = 1'b1;
        end else begin
          r.st.shift   = {s.shift[6:0], sda_in};
          r.st.bit_cnt = s.bit_cnt + 4'd1;
          r.st.scl     = 1'b0;
        end
      end
      CMD_START, CMD_STOP, CMD_ACK, CMD_NACK, CMD_WAIT_ACK, CMD_WACK_TAIL: begin
        if (idx == 5'd0) begin
          r.st.sda_en = 1'b1;
          if (s.cmd == CMD_WAIT_ACK || s.cmd == CMD_WACK_TAIL) r.st.ack_fail = 1'b0;
        end else if (idx <= TAB_LAST_PHASE) begin
          case (s.cmd)
            CMD_START: begin
              case (idx)
                5'd1:    r.st.sda = 1'b1;
                5'd2:    r.st.scl = 1'b1;
                5'd3:    r.st.sda = 1'b0;
                default: r.st.scl = 1'b0;
              endcase
            end
            CMD_STOP: begin
              case (idx)
                5'd1:    r.st.scl = 1'b0;
                5'd2:    r.st.sda = 1'b0;
                5'd3:    r.st.scl = 1'b1;
                default: r.st.sda = 1'b1;
              endcase
            end
            CMD_ACK, CMD_NACK: begin
              case (idx)
                5'd1:    r.st.scl = 1'b0;
                5'd2:    r.st.sda = (s.cmd == CMD_NACK);
                5'd3:    r.st.scl = 1'b1;
                default: r.st.scl = 1'b0;
              endcase
            end
            default: begin
              case (idx)
                5'd1:    r.st.sda    = 1'b1;
                5'd2:    r.st.sda_en = 1'b0;
                5'd3:    r.st.scl    = 1'b0;
                default: r.st.scl    = 1'b1;
              endcase
            end
          endcase
        end else if ((s.cmd == CMD_WAIT_ACK || s.cmd == CMD_WACK_TAIL) &&
                     idx == POLL_PHASE) begin
          r.st.poll_cnt = 4'd0;
        end else begin
          r.ok = 1'b0;
        end
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/i2c_master_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master pin sequencer: one command at a time, each input transaction is
// one tick that advances the SCL/SDA phase sequence.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: every transaction is one tick. tuser carries the command
//    code; tdata carries the byte to write and the sampled SDA level. Code 0
//    only advances time. A command is taken only when the sequencer is idle.
//  - Output stream: exactly one result transaction per input transaction,
//    holding the pin levels, busy/done, last read byte, ack failure flag and
//    the command status (invalid code, or rejected while busy).
//  - Each tick is evaluated by the next-state logic and lands in the state
//    and result registers on the accepting edge. Throughput is one
//    transaction per cycle while the sink does not stall.
//  - The result register decouples the sides: input is taken while a result
//    is waiting, provided the sink takes it in the same cycle. A stalled
//    sink holds the result and stalls the input.
//  - Config: cfg index 0 sets ticks per phase, 1 the ack poll limit. Write
//    only while idle; the port is always ready.
//  - Reset: SCL, SDA high and driven, sequencer idle, registers at defaults.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer #(
  parameter int TICK_COUNTER_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [8] sda_sample, rest zero
  input  logic [3:0]  s_axis_tuser,  // [3:0] func
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] read_data, [13] ack_fail, [15:14] cmd_status
  output logic [15:0] m_axis_tdata,
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int TW = TICK_COUNTER_WIDTH;
  localparam int CW = (TW > 16) ? TW : 16;  // compare width
  localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

  i2cbs_pkg::seq_state_t st_q, st_d;
  logic [TW-1:0] tick_q, tick_d;
  logic [15:0]   phase_ticks_q;
  logic [3:0]    poll_limit_q;
  logic          out_valid_q;
  logic [15:0]   out_data_q, out_data_d;
  logic          accept;

  // Combinational tick evaluation
  logic [3:0]    func;
  logic          sda_in;
  logic [1:0]    status;
  logic          done;
  logic [TW-1:0] tick_inc;
  logic [3:0]    poll_inc;
  i2cbs_pkg::enter_res_t e1, e2;
  i2cbs_pkg::seq_state_t tmp;

  assign func   = s_axis_tuser;
  assign sda_in = s_axis_tdata[8];

  always_comb begin
    st_d     = st_q;
    tick_d   = tick_q;
    status   = i2cbs_pkg::STS_OK;
    done     = 1'b0;
    tick_inc = (tick_q != TICK_MAX) ? tick_q + TW'(1) : tick_q;
    poll_inc = (st_q.poll_cnt < i2cbs_pkg::POLL_CNT_MAX) ? st_q.poll_cnt + 4'd1
                                                        : st_q.poll_cnt;
    tmp      = st_q;
    e1       = '0;
    e2       = '0;

    if (st_q.cmd == i2cbs_pkg::CMD_NONE) begin
      if (func > i2cbs_pkg::CMD_LAST) begin
        status = i2cbs_pkg::STS_INVALID;
      end else if (func != i2cbs_pkg::CMD_NONE) begin
        tmp.cmd   = func;
        tmp.phase = 5'd0;
        if (func == i2cbs_pkg::CMD_WRITE || func == i2cbs_pkg::CMD_WRITE_ACK) begin
          tmp.shift = s_axis_tdata[7:0];
        end
        e1     = i2cbs_pkg::enter_phase(tmp, sda_in);
        st_d   = e1.st;
        tick_d = '0;
      end
    end else begin
      if (func != i2cbs_pkg::CMD_NONE) status = i2cbs_pkg::STS_BUSY;
      if ((st_q.cmd == i2cbs_pkg::CMD_WAIT_ACK || st_q.cmd == i2cbs_pkg::CMD_WACK_TAIL) &&
          st_q.phase == i2cbs_pkg::POLL_PHASE) begin
        // Ack poll: one SDA sample per tick
        if (!sda_in) begin
          st_d.ack_fail = 1'b0;
          st_d.scl      = 1'b0;
          st_d.cmd      = i2cbs_pkg::CMD_NONE;
          st_d.phase    = 5'd0;
          tick_d        = '0;
          done          = 1'b1;
        end else begin
          st_d.poll_cnt = poll_inc;
          if (poll_inc >= poll_limit_q) begin
            tmp          = st_q;
            tmp.poll_cnt = poll_inc;
            tmp.ack_fail = 1'b1;
            tmp.scl      = 1'b0;
            if (st_q.cmd == i2cbs_pkg::CMD_WACK_TAIL) begin
              // failed ack after a write: finish with a stop
              tmp.cmd   = i2cbs_pkg::CMD_STOP;
              tmp.phase = 5'd0;
              e1        = i2cbs_pkg::enter_phase(tmp, sda_in);
              st_d      = e1.st;
              tick_d    = '0;
            end else begin
              st_d       = tmp;
              st_d.cmd   = i2cbs_pkg::CMD_NONE;
              st_d.phase = 5'd0;
              tick_d     = '0;
              done       = 1'b1;
            end
          end
        end
      end else if (CW'(tick_inc) >= CW'(phase_ticks_q) || tick_inc == TICK_MAX) begin
        // Hold over: step to the next phase
        tmp.phase = st_q.phase + 5'd1;
        e1        = i2cbs_pkg::enter_phase(tmp, sda_in);
        tick_d    = '0;
        if (e1.ok) begin
          st_d = e1.st;
        end else if (st_q.cmd == i2cbs_pkg::CMD_WRITE_ACK) begin
          tmp       = e1.st;
          tmp.cmd   = i2cbs_pkg::CMD_WACK_TAIL;
          tmp.phase = 5'd0;
          e2        = i2cbs_pkg::enter_phase(tmp, sda_in);
          st_d      = e2.st;
        end else begin
          st_d       = e1.st;
          st_d.cmd   = i2cbs_pkg::CMD_NONE;
          st_d.phase = 5'd0;
          done       = 1'b1;
        end
      end else begin
        tick_d = tick_inc;
      end
    end

    out_data_d = {status, st_d.ack_fail, st_d.read_byte, done,
                  (st_d.cmd != i2cbs_pkg::CMD_NONE), st_d.sda_en, st_d.sda, st_d.scl};
  end

  // Handshake: result register frees when the sink takes it
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // lines high and driven, everything else cleared
      st_q           <= '{scl: 1'b1, sda: 1'b1, sda_en: 1'b1, default: '0};
      tick_q         <= '0;
      out_valid_q    <= 1'b0;
      phase_ticks_q  <= i2cbs_pkg::PHASE_TICKS_RST;
      poll_limit_q   <= i2cbs_pkg::POLL_LIMIT_RST;
    end else begin
      if (accept) begin
        st_q        <= st_d;
        tick_q      <= tick_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          i2cbs_pkg::REG_PHASE_TICKS:    phase_ticks_q <= cfg_data_i;
          i2cbs_pkg::REG_ACK_POLL_LIMIT: poll_limit_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) out_data_q <= out_data_d;
  end

endmodule
